// ===== sv/crt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg: shared types and constants for the CRT merge unit
// Port widths, datapath operation codes, command and status bundles.
// ----------------------------------------------------------------------------
package crt_pkg;

	localparam int RES_W      = 31;   // input field width
	localparam int ACC_W      = 63;   // result field width
	localparam int MOD_BITS_D = 31;   // default modulus width
	localparam int ACC_BITS_D = 63;   // default accumulator width

	localparam int IN_DATA_W  = 64;   // 2*RES_W rounded up to bytes
	localparam int OUT_DATA_W = 128;  // 2*ACC_W rounded up to bytes

	// datapath operations, one per cycle
	localparam logic [4:0] OP_NONE      = 5'd0;
	localparam logic [4:0] OP_LOAD      = 5'd1;
	localparam logic [4:0] OP_FIRST_BIG = 5'd2;
	localparam logic [4:0] OP_DIV_FIRST = 5'd3;
	localparam logic [4:0] OP_FIRST_SET = 5'd4;
	localparam logic [4:0] OP_DIV_A     = 5'd5;
	localparam logic [4:0] OP_GCD_INIT  = 5'd6;
	localparam logic [4:0] OP_DIV_GCD   = 5'd7;
	localparam logic [4:0] OP_GCD_STEP  = 5'd8;
	localparam logic [4:0] OP_DIV_B1    = 5'd9;
	localparam logic [4:0] OP_B1M       = 5'd10;
	localparam logic [4:0] OP_DIV_B2    = 5'd11;
	localparam logic [4:0] OP_DIFF      = 5'd12;
	localparam logic [4:0] OP_DIV_DIFF  = 5'd13;
	localparam logic [4:0] OP_KQ        = 5'd14;
	localparam logic [4:0] OP_DIV_N     = 5'd15;
	localparam logic [4:0] OP_N         = 5'd16;
	localparam logic [4:0] OP_MUL_N     = 5'd17;
	localparam logic [4:0] OP_MN_CHECK  = 5'd18;
	localparam logic [4:0] OP_DIV_E     = 5'd19;
	localparam logic [4:0] OP_INV_INIT  = 5'd20;
	localparam logic [4:0] OP_DIV_INV   = 5'd21;
	localparam logic [4:0] OP_INV_STEP  = 5'd22;
	localparam logic [4:0] OP_KI        = 5'd23;
	localparam logic [4:0] OP_DIV_T     = 5'd24;
	localparam logic [4:0] OP_T         = 5'd25;
	localparam logic [4:0] OP_MUL_T     = 5'd26;
	localparam logic [4:0] OP_COMMIT    = 5'd27;
	localparam logic [4:0] OP_PUBLISH   = 5'd28;

	typedef struct packed {
		logic [4:0] op;
	} crt_cmd_t;

	typedef struct packed {
		logic div_done;
		logic mul_done;
		logic is_first;
		logic sticky;    // failed or overflow held
		logic mod_big;   // first modulus beyond accumulator
		logic gb_zero;   // gcd loop finished
		logic rem_zero;  // divider remainder is zero
		logic prod_big;  // product beyond accumulator
		logic n_one;
		logic r1_zero;   // inverse loop finished
		logic out_free;
	} crt_sts_t;

endpackage

// ===== sv/crt_congruence_merge_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_congruence_merge_unit: streaming Chinese-remainder merge
// Folds congruences x = residue (mod modulus) into one running congruence.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one congruence per item. tuser=1 starts a new system and
//   clears the sticky flags; other items merge into the running congruence.
//   Master channel: one result per item, the running residue and modulus
//   after the update, with the consistent and overflowed flags in tuser.
//   Items are worked one at a time. A first item takes at most one serial
//   division. A merge takes one serial division per Euclid step of the gcd
//   and of the modular inverse, seven more divisions (five when the new
//   modulus adds no factor), and two shift-add multiplies. The shared
//   divider works one quotient bit per cycle. Once the failed or overflow
//   flag is held, a merge item just repeats the held state. Reset loads
//   x = 0 (mod 1) with both flags clear and empties the output register.
//   A result waiting on a stalled receiver is held; the next item is
//   accepted and worked meanwhile, but its result waits for the slot.
// ----------------------------------------------------------------------------
module crt_congruence_merge_unit
	import crt_pkg::*;
#(
	parameter int MODULUS_BITS = MOD_BITS_D,
	parameter int ACC_BITS     = ACC_BITS_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // residue[30:0], modulus[61:31], zero
	input  logic                  s_tuser,   // first
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // combined_residue[62:0], combined_modulus[125:63], zero
	output logic [1:0]            m_tuser    // consistent[0], overflowed[1]
);

	crt_cmd_t         cmd;
	crt_sts_t         sts;
	logic [ACC_W-1:0] res_out, mod_out;
	logic             cons_out, ovf_out;

	crt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath latches the item on OP_LOAD, which only issues on acceptance
	crt_datapath #(
		.MB (MODULUS_BITS),
		.AB (ACC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_residue     (s_tdata[RES_W-1:0]),
		.in_modulus     (s_tdata[2*RES_W-1:RES_W]),
		.in_first       (s_tuser),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_residue    (res_out),
		.out_modulus    (mod_out),
		.out_consistent (cons_out),
		.out_overflowed (ovf_out)
	);

	assign m_tdata = {{(OUT_DATA_W - 2 * ACC_W){1'b0}}, mod_out, res_out};
	assign m_tuser = {ovf_out, cons_out};

endmodule

// ===== sv/crt_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_divider: serial restoring divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module crt_divider #(
	parameter int DW = 63,
	parameter int VW = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quot,
	output logic [VW-1:0] rem,
	output logic          done
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          ge;
	logic [VW:0]   diff;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign quot = dvd_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

// ===== sv/crt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_datapath: running congruence, Euclid temporaries and arithmetic units
// Executes one operation code per cycle; holds the output register.
// ----------------------------------------------------------------------------
module crt_datapath
	import crt_pkg::*;
#(
	parameter int MB = MOD_BITS_D,
	parameter int AB = ACC_BITS_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  crt_cmd_t          cmd,
	output crt_sts_t          sts,
	input  logic [RES_W-1:0]  in_residue,
	input  logic [RES_W-1:0]  in_modulus,
	input  logic              in_first,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ACC_W-1:0]  out_residue,
	output logic [ACC_W-1:0]  out_modulus,
	output logic              out_consistent,
	output logic              out_overflowed
);

	localparam int DW  = (AB > 2 * MB) ? AB : 2 * MB;
	localparam int PW  = AB + MB;
	localparam int SW  = MB + 2;
	localparam int MCW = $clog2(MB + 1);

	logic [MB-1:0] b2_q, m2_q;
	logic          first_q;
	logic [AB-1:0] b1_q, m1_q, newmod_q;
	logic          failed_q, ovf_q;
	logic [MB-1:0] ga_q, gb_q, a_q, b1m_q, diff_q, k_q, n_q, r0_q, r1_q, t_q;
	logic signed [SW-1:0] s0_q, s1_q;
	logic [2*MB-1:0] kinv_q;

	// serial multiplier
	logic [PW-1:0]  mul_acc_q;
	logic [MB-1:0]  mul_mpl_q;
	logic [MCW-1:0] mul_cnt_q;
	logic           mul_busy_q, mul_done_q;

	// output register
	logic             ov_q;
	logic [ACC_W-1:0] ores_q, omod_q;
	logic             ocons_q, oovf_q;

	// divider
	logic          div_start;
	logic [DW-1:0] div_dvd, div_quot;
	logic [MB-1:0] div_dvs, div_rem;
	logic          div_done;

	crt_divider #(.DW(DW), .VW(MB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quot     (div_quot),
		.rem      (div_rem),
		.done     (div_done)
	);

	always_comb begin
		div_start = 1'b1;
		div_dvd   = DW'(b2_q);
		div_dvs   = m2_q;
		case (cmd.op)
			OP_DIV_FIRST: begin div_dvd = DW'(b2_q);   div_dvs = m2_q; end
			OP_DIV_A:     begin div_dvd = DW'(m1_q);   div_dvs = m2_q; end
			OP_DIV_GCD:   begin div_dvd = DW'(ga_q);   div_dvs = gb_q; end
			OP_DIV_B1:    begin div_dvd = DW'(b1_q);   div_dvs = m2_q; end
			OP_DIV_B2:    begin div_dvd = DW'(b2_q);   div_dvs = m2_q; end
			OP_DIV_DIFF:  begin div_dvd = DW'(diff_q); div_dvs = ga_q; end
			OP_DIV_N:     begin div_dvd = DW'(m2_q);   div_dvs = ga_q; end
			OP_DIV_E:     begin div_dvd = DW'(a_q);    div_dvs = ga_q; end
			OP_DIV_INV:   begin div_dvd = DW'(r0_q);   div_dvs = r1_q; end
			OP_DIV_T:     begin div_dvd = DW'(kinv_q); div_dvs = n_q;  end
			default:      div_start = 1'b0;
		endcase
	end

	// input masking, zero modulus counts as one
	logic [MB-1:0] mod_in;
	assign mod_in = (in_modulus[MB-1:0] == '0) ? MB'(1) : in_modulus[MB-1:0];

	// residue difference mod m2
	logic [MB:0] diff_sum;
	assign diff_sum = (div_rem >= b1m_q) ? {1'b0, div_rem} - {1'b0, b1m_q}
	                                     : {1'b0, div_rem} + {1'b0, m2_q} - {1'b0, b1m_q};

	// extended Euclid coefficient update
	logic [MB-1:0]            q_lo;
	logic signed [2*MB+2:0]   qs_prod;
	logic signed [SW-1:0]     s1_next;
	assign q_lo    = div_quot[MB-1:0];
	assign qs_prod = $signed({1'b0, q_lo}) * s1_q;
	assign s1_next = s0_q - $signed(qs_prod[SW-1:0]);

	logic [SW-1:0]   inv_adj;
	logic [2*MB-1:0] kinv_next;
	assign inv_adj   = s0_q[SW-1] ? SW'(s0_q) + SW'(n_q) : SW'(s0_q);
	assign kinv_next = k_q * inv_adj[MB-1:0];

	logic [PW-1:0] m2_ext;
	assign m2_ext = PW'(m2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_q     <= '0;
			m1_q     <= AB'(1);
			failed_q <= 1'b0;
			ovf_q    <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			// publish only issues when the slot is free or draining
			if (cmd.op == OP_PUBLISH)
				ov_q <= 1'b1;
			else if (ov_q && out_ready)
				ov_q <= 1'b0;
			case (cmd.op)
				OP_FIRST_BIG: begin
					b1_q     <= '0;
					m1_q     <= AB'(1);
					failed_q <= 1'b0;
					ovf_q    <= 1'b1;
				end
				OP_FIRST_SET: begin
					b1_q     <= AB'(div_rem);
					m1_q     <= AB'(m2_q);
					failed_q <= 1'b0;
					ovf_q    <= 1'b0;
				end
				OP_KQ: begin
					if (div_rem != '0)
						failed_q <= 1'b1;
				end
				OP_MN_CHECK: begin
					if (sts.prod_big)
						ovf_q <= 1'b1;
				end
				OP_COMMIT: begin
					b1_q <= b1_q + mul_acc_q[AB-1:0];
					m1_q <= newmod_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				b2_q    <= in_residue[MB-1:0];
				m2_q    <= mod_in;
				first_q <= in_first;
			end
			OP_GCD_INIT: begin
				ga_q <= m2_q;
				gb_q <= div_rem;
				a_q  <= div_rem;
			end
			OP_GCD_STEP: begin
				ga_q <= gb_q;
				gb_q <= div_rem;
			end
			OP_B1M:      b1m_q  <= div_rem;
			OP_DIFF:     diff_q <= diff_sum[MB-1:0];
			OP_KQ:       k_q    <= div_quot[MB-1:0];
			OP_N:        n_q    <= div_quot[MB-1:0];
			OP_MN_CHECK: begin
				newmod_q <= mul_acc_q[AB-1:0];
				t_q      <= '0;
			end
			OP_INV_INIT: begin
				r0_q <= div_quot[MB-1:0];
				r1_q <= n_q;
				s0_q <= SW'(1);
				s1_q <= '0;
			end
			OP_INV_STEP: begin
				r0_q <= r1_q;
				r1_q <= div_rem;
				s0_q <= s1_q;
				s1_q <= s1_next;
			end
			OP_KI:       kinv_q <= kinv_next;
			OP_T:        t_q    <= div_rem;
			OP_PUBLISH: begin
				ores_q  <= ACC_W'(b1_q);
				omod_q  <= ACC_W'(m1_q);
				ocons_q <= ~failed_q;
				oovf_q  <= ovf_q;
			end
			default: ;
		endcase
	end

	// shift-add multiplier, m1 times n or t, MSB of the multiplier first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_done_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else begin
			mul_done_q <= 1'b0;
			if (cmd.op == OP_MUL_N || cmd.op == OP_MUL_T) begin
				mul_busy_q <= 1'b1;
				mul_cnt_q  <= MCW'(MB);
			end else if (mul_busy_q) begin
				mul_cnt_q <= mul_cnt_q - 1'b1;
				if (mul_cnt_q == MCW'(1)) begin
					mul_busy_q <= 1'b0;
					mul_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MUL_N || cmd.op == OP_MUL_T) begin
			mul_acc_q <= '0;
			mul_mpl_q <= (cmd.op == OP_MUL_N) ? n_q : t_q;
		end else if (mul_busy_q) begin
			mul_acc_q <= {mul_acc_q[PW-2:0], 1'b0}
			           + (mul_mpl_q[MB-1] ? PW'(m1_q) : '0);
			mul_mpl_q <= {mul_mpl_q[MB-2:0], 1'b0};
		end
	end

	always_comb begin
		sts.div_done = div_done;
		sts.mul_done = mul_done_q;
		sts.is_first = first_q;
		sts.sticky   = failed_q | ovf_q;
		sts.mod_big  = |m2_ext[PW-1:AB];
		sts.gb_zero  = (gb_q == '0);
		sts.rem_zero = (div_rem == '0);
		sts.prod_big = |mul_acc_q[PW-1:AB];
		sts.n_one    = (n_q == MB'(1));
		sts.r1_zero  = (r1_q == '0);
		sts.out_free = ~ov_q | out_ready;
	end

	assign out_valid      = ov_q;
	assign out_residue    = ores_q;
	assign out_modulus    = omod_q;
	assign out_consistent = ocons_q;
	assign out_overflowed = oovf_q;

endmodule

// ===== sv/crt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_ctrl: sequencer for the CRT merge
// Walks load, gcd, divisibility, overflow check, inverse, commit and publish.
// ----------------------------------------------------------------------------
module crt_ctrl
	import crt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output crt_cmd_t cmd,
	input  crt_sts_t sts
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_CHK     = 5'd1;
	localparam logic [4:0] S_W_FIRST = 5'd2;
	localparam logic [4:0] S_W_A     = 5'd3;
	localparam logic [4:0] S_G_TEST  = 5'd4;
	localparam logic [4:0] S_W_G     = 5'd5;
	localparam logic [4:0] S_W_B1    = 5'd6;
	localparam logic [4:0] S_B2      = 5'd7;
	localparam logic [4:0] S_W_B2    = 5'd8;
	localparam logic [4:0] S_D1      = 5'd9;
	localparam logic [4:0] S_W_D1    = 5'd10;
	localparam logic [4:0] S_N       = 5'd11;
	localparam logic [4:0] S_W_N     = 5'd12;
	localparam logic [4:0] S_MN      = 5'd13;
	localparam logic [4:0] S_W_MN    = 5'd14;
	localparam logic [4:0] S_E       = 5'd15;
	localparam logic [4:0] S_W_E     = 5'd16;
	localparam logic [4:0] S_I_TEST  = 5'd17;
	localparam logic [4:0] S_W_I     = 5'd18;
	localparam logic [4:0] S_KI      = 5'd19;
	localparam logic [4:0] S_T       = 5'd20;
	localparam logic [4:0] S_W_T     = 5'd21;
	localparam logic [4:0] S_MT      = 5'd22;
	localparam logic [4:0] S_W_MT    = 5'd23;
	localparam logic [4:0] S_OUT     = 5'd24;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.is_first) begin
					if (sts.mod_big) begin
						cmd.op  = OP_FIRST_BIG;
						state_d = S_OUT;
					end else begin
						cmd.op  = OP_DIV_FIRST;
						state_d = S_W_FIRST;
					end
				end else if (sts.sticky) begin
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_DIV_A;
					state_d = S_W_A;
				end
			end
			S_W_FIRST: if (sts.div_done) begin
				cmd.op  = OP_FIRST_SET;
				state_d = S_OUT;
			end
			S_W_A: if (sts.div_done) begin
				cmd.op  = OP_GCD_INIT;
				state_d = S_G_TEST;
			end
			S_G_TEST: begin
				if (sts.gb_zero) begin
					cmd.op  = OP_DIV_B1;
					state_d = S_W_B1;
				end else begin
					cmd.op  = OP_DIV_GCD;
					state_d = S_W_G;
				end
			end
			S_W_G: if (sts.div_done) begin
				cmd.op  = OP_GCD_STEP;
				state_d = S_G_TEST;
			end
			S_W_B1: if (sts.div_done) begin
				cmd.op  = OP_B1M;
				state_d = S_B2;
			end
			S_B2: begin
				cmd.op  = OP_DIV_B2;
				state_d = S_W_B2;
			end
			S_W_B2: if (sts.div_done) begin
				cmd.op  = OP_DIFF;
				state_d = S_D1;
			end
			S_D1: begin
				cmd.op  = OP_DIV_DIFF;
				state_d = S_W_D1;
			end
			S_W_D1: if (sts.div_done) begin
				cmd.op  = OP_KQ;
				state_d = sts.rem_zero ? S_N : S_OUT;
			end
			S_N: begin
				cmd.op  = OP_DIV_N;
				state_d = S_W_N;
			end
			S_W_N: if (sts.div_done) begin
				cmd.op  = OP_N;
				state_d = S_MN;
			end
			S_MN: begin
				cmd.op  = OP_MUL_N;
				state_d = S_W_MN;
			end
			S_W_MN: if (sts.mul_done) begin
				cmd.op = OP_MN_CHECK;
				if (sts.prod_big)
					state_d = S_OUT;
				else if (sts.n_one)
					state_d = S_MT;
				else
					state_d = S_E;
			end
			S_E: begin
				cmd.op  = OP_DIV_E;
				state_d = S_W_E;
			end
			S_W_E: if (sts.div_done) begin
				cmd.op  = OP_INV_INIT;
				state_d = S_I_TEST;
			end
			S_I_TEST: begin
				if (sts.r1_zero) begin
					state_d = S_KI;
				end else begin
					cmd.op  = OP_DIV_INV;
					state_d = S_W_I;
				end
			end
			S_W_I: if (sts.div_done) begin
				cmd.op  = OP_INV_STEP;
				state_d = S_I_TEST;
			end
			S_KI: begin
				cmd.op  = OP_KI;
				state_d = S_T;
			end
			S_T: begin
				cmd.op  = OP_DIV_T;
				state_d = S_W_T;
			end
			S_W_T: if (sts.div_done) begin
				cmd.op  = OP_T;
				state_d = S_MT;
			end
			S_MT: begin
				cmd.op  = OP_MUL_T;
				state_d = S_W_MT;
			end
			S_W_MT: if (sts.mul_done) begin
				cmd.op  = OP_COMMIT;
				state_d = S_OUT;
			end
			S_OUT: if (sts.out_free) begin
				cmd.op  = OP_PUBLISH;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

// ===== sv/crt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_checker: port-level checks for the CRT merge unit
// Bound to the top level.
// ----------------------------------------------------------------------------
module crt_checker
	import crt_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]            m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_res_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ACC_W-1:0] < m_tdata[2*ACC_W-1:ACC_W])
		else $error("residue not below modulus");

	a_mod_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2*ACC_W-1:ACC_W] != '0)
		else $error("zero combined modulus");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while working");

endmodule

bind crt_congruence_merge_unit crt_checker u_crt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== test/crt_merge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_merge_checker: predicts and checks CRT merge results
// Watches both channels, keeps its own running congruence and flags, and
// compares each result item with the oldest predicted one.
// ----------------------------------------------------------------------------
module crt_merge_checker
	import crt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [1:0]            m_tuser,
	output int                    fail_count,
	output int                    pending,
	output int                    merges_seen,
	output int                    bad_systems
);

	typedef struct packed {
		logic [ACC_W-1:0] res;
		logic [ACC_W-1:0] modu;
		logic             ok;
		logic             ovf;
	} crt_state_t;

	localparam logic [63:0] ACC_MAX = (64'd1 << ACC_W) - 64'd1;

	crt_state_t sys;
	crt_state_t merged_q[$];

	function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
		logic [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic logic [63:0] inv_mod(logic [63:0] a, logic [63:0] n);
		longint r0, r1, s0, s1, q, t;
		r0 = longint'(a % n);
		r1 = longint'(n);
		s0 = 1;
		s1 = 0;
		while (r1 != 0) begin
			q = r0 / r1;
			t = r0 - q * r1;
			r0 = r1;
			r1 = t;
			t = s0 - q * s1;
			s0 = s1;
			s1 = t;
		end
		if (s0 < 0)
			s0 += longint'(n);
		return 64'(s0) % n;
	endfunction

	function automatic crt_state_t fold(crt_state_t st, logic [30:0] r_in,
			logic [30:0] m_in, logic first);
		logic [63:0] b1, m1, b2, m2, d, b1m, b2m, diffm, n, t;
		b2 = 64'(r_in);
		m2 = (m_in == 0) ? 64'd1 : 64'(m_in);
		if (first) begin
			st.ok = 1'b1;
			st.ovf = 1'b0;
			st.res = ACC_W'(b2 % m2);
			st.modu = ACC_W'(m2);
			return st;
		end
		if (!st.ok || st.ovf)
			return st;
		b1 = 64'(st.res);
		m1 = 64'(st.modu);
		d = gcd64(m2, m1 % m2);
		b1m = b1 % m2;
		b2m = b2 % m2;
		diffm = (b2m >= b1m) ? (b2m - b1m) : (b2m + m2 - b1m);
		if (diffm % d != 0) begin
			st.ok = 1'b0;
			return st;
		end
		n = m2 / d;
		if (m1 > ACC_MAX / n) begin
			st.ovf = 1'b1;
			return st;
		end
		// quotient reduced mod n first keeps k*inv below 2^62
		t = (n == 1) ? 64'd0 : (((diffm / d) % n) * inv_mod(m1 / d, n)) % n;
		st.res = ACC_W'(b1 + m1 * t);
		st.modu = ACC_W'(m1 * n);
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crt_state_t got, want;
		if (!arst_n) begin
			sys <= '{res: '0, modu: ACC_W'(1), ok: 1'b1, ovf: 1'b0};
			merged_q.delete();
			fail_count <= 0;
			merges_seen <= 0;
			bad_systems <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				want = fold(sys, s_tdata[30:0], s_tdata[61:31], s_tuser);
				if (!s_tuser && sys.ok && !sys.ovf)
					merges_seen <= merges_seen + 1;
				if ((!want.ok || want.ovf) && sys.ok && !sys.ovf)
					bad_systems <= bad_systems + 1;
				sys <= want;
				merged_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = '{res: m_tdata[62:0], modu: m_tdata[125:63],
					ok: m_tuser[0], ovf: m_tuser[1]};
				if (merged_q.size() == 0) begin
					$error("result item with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = merged_q.pop_front();
					if (got != want) begin
						fail_count <= fail_count + 1;
						if (got.res != want.res)
							$error("combined_residue: expected %0d, got %0d",
								want.res, got.res);
						if (got.modu != want.modu)
							$error("combined_modulus: expected %0d, got %0d",
								want.modu, got.modu);
						if (got.ok != want.ok)
							$error("consistent: expected %0d, got %0d", want.ok, got.ok);
						if (got.ovf != want.ovf)
							$error("overflowed: expected %0d, got %0d", want.ovf, got.ovf);
					end
				end
			end
		end
	end

	assign pending = merged_q.size();

endmodule

// ===== test/crt_congruence_merge_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_congruence_merge_unit_test: regression for the CRT merge unit
// Directed congruence systems (zero and full-width moduli, inconsistent and
// overflowing merges, merges before any first item), then random systems
// built from a hidden solution, with random gaps on both channels.
// ----------------------------------------------------------------------------
module crt_congruence_merge_unit_test;
	import crt_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	int fail_count, pending, merges_seen, bad_systems;
	int cycle_count;
	int items_sent;
	bit hold_rx;       // long receiver hold-off request
	bit rx_held_done;

	crt_congruence_merge_unit u_top (.*);

	crt_merge_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("crt_congruence_merge_unit regression: fail");
			$finish;
		end
	end
	initial cycle_count = 0;

	function automatic int gap_len();
		// mostly short, now and then long
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		m_tready = 1'b0;
		rx_held_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx && !rx_held_done) begin
				m_tready <= 1'b0;
				repeat (30000) @(posedge clk);
				rx_held_done = 1'b1;
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 2) == 0) begin
				n = gap_len();
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send(logic [30:0] res, logic [30:0] modu, logic first, bit gaps);
		int n;
		n = gaps ? (($urandom_range(0, 3) == 0) ? gap_len() : 0) : 0;
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b0, modu, res};
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	// random system: congruences that share a hidden solution, sometimes broken
	task automatic random_system(bit gaps);
		logic [61:0] x;
		logic [30:0] m, r;
		int len, kind;
		x = 62'({$urandom(), $urandom()});
		len = $urandom_range(1, 5);
		for (int i = 0; i < len; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0: m = 31'($urandom());                      // full width
				1, 2: m = 31'($urandom_range(1, 255));
				3: m = 31'($urandom_range(0, 3));            // zero and tiny
				default: m = 31'($urandom_range(2, 65535));
			endcase
			r = (m == 0) ? 31'($urandom()) : 31'(x % m);
			if ($urandom_range(0, 7) == 0)
				r = 31'($urandom());                         // likely inconsistent
			else if ($urandom_range(0, 3) == 0 && m != 0)
				r = r + m * 31'($urandom_range(0, 3));       // unreduced residue
			send(r, m, i == 0 && $urandom_range(0, 15) != 0, gaps);
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		hold_rx  = 1'b0;
		items_sent = 0;
		@(posedge arst_n);
		@(posedge clk);

		// merge before any first item: starts from x = 0 mod 1
		send(31'd5, 31'd7, 1'b0, 0);
		send(31'd2, 31'd5, 1'b0, 0);
		// zero modulus treated as one, all-ones residue
		send(31'h7fffffff, 31'd0, 1'b1, 0);
		send(31'h7fffffff, 31'h7fffffff, 1'b0, 0);
		// full-width moduli overflow the accumulator
		send(31'd0, 31'h7ffffffe, 1'b0, 0);
		send(31'd1, 31'h7ffffffd, 1'b0, 0);
		send(31'd3, 31'd11, 1'b0, 0);     // ignored while sticky
		// inconsistent: x=1 mod 4 then x=2 mod 6
		send(31'd1, 31'd4, 1'b1, 0);
		send(31'd2, 31'd6, 1'b0, 0);
		send(31'd0, 31'd9, 1'b0, 0);      // ignored
		// consistent shared factor: x=3 mod 4, x=5 mod 6, x=11 mod 12
		send(31'd3, 31'd4, 1'b1, 0);
		send(31'd5, 31'd6, 1'b0, 0);
		send(31'd11, 31'd12, 1'b0, 0);
		send(31'd7, 31'd1, 1'b0, 0);      // modulus one
		send(31'h55555555, 31'h2aaaaaab, 1'b1, 0);
		send(31'h2aaaaaaa, 31'h55555555, 1'b0, 0);
		drain();

		// long receiver hold-off while items keep coming
		hold_rx = 1'b1;
		for (int i = 0; i < 6; i++) send(31'($urandom()), 31'($urandom_range(1, 9)), i == 0, 0);
		while (!rx_held_done) @(posedge clk);
		hold_rx = 1'b0;
		drain();

		// random systems; stretches with no gaps on the sender side
		while (items_sent < 200)
			random_system(($urandom_range(0, 3) != 0));
		drain();
		repeat (6000) @(posedge clk);

		$display("covered %0d items, %0d live merges, %0d systems gone sticky",
			items_sent, merges_seen, bad_systems);
		if (fail_count == 0)
			$display("crt_congruence_merge_unit regression: pass");
		else
			$display("crt_congruence_merge_unit regression: fail");
		$finish;
	end

endmodule
